[src/sha1_message_hasher_macros.svh]
// assertion macros shared by the sha1 message hasher modules
// expects clk and rst_n to be visible where a macro is used
`ifndef SHA1_MESSAGE_HASHER_MACROS_SVH
`define SHA1_MESSAGE_HASHER_MACROS_SVH

// consequent must hold in the same cycle
`define SHA1MH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the next cycle
`define SHA1MH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sha1mh_pkg.sv]
// types, constants and round functions for the sha1 message hasher
// no dependencies
`default_nettype none

package sha1mh_pkg;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
    } out_item_t;

    localparam int COUNT_W = 61;
    localparam int POS_W   = 6;
    localparam int ROUND_W = 7;
    localparam int WIN_D   = 16;

    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(79);
    localparam logic [POS_W-1:0]   POS_BLOCK_END = POS_W'(63);
    localparam logic [POS_W-1:0]   POS_BEFORE_LEN = POS_W'(55);

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [31:0] H_INIT [0:4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [31:0] K_R0 = 32'h5a827999;
    localparam logic [31:0] K_R1 = 32'h6ed9eba1;
    localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_R3 = 32'hca62c1d6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_UPDATE,
        ST_DIGEST
    } state_t;

    typedef enum logic [1:0] {
        SRC_MSG,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef struct packed {
        logic               push;
        byte_src_t          src;
        logic               count_inc;
        logic               load_work;
        logic               round_en;
        logic [ROUND_W-1:0] round_idx;
        logic               update_h;
        logic               digest_load;
    } cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_pre_len;
        logic out_hold;
    } status_t;

    function automatic logic [31:0] sha1mh_round_f(
        input logic [ROUND_W-1:0] rnd,
        input logic [31:0]        b,
        input logic [31:0]        c,
        input logic [31:0]        d
    );
        logic [31:0] f;
        priority if (rnd < ROUND_W'(20)) f = (b & c) ^ (~b & d);
        else if (rnd < ROUND_W'(40))     f = b ^ c ^ d;
        else if (rnd < ROUND_W'(60))     f = (b & c) ^ (b & d) ^ (c & d);
        else                             f = b ^ c ^ d;
        return f;
    endfunction

    function automatic logic [31:0] sha1mh_round_k(input logic [ROUND_W-1:0] rnd);
        logic [31:0] k;
        priority if (rnd < ROUND_W'(20)) k = K_R0;
        else if (rnd < ROUND_W'(40))     k = K_R1;
        else if (rnd < ROUND_W'(60))     k = K_R2;
        else                             k = K_R3;
        return k;
    endfunction

endpackage

`default_nettype wire

[src/sha1mh_ctrl.sv]
// sequencer for the sha1 message hasher: byte intake, padding, rounds, digest
// depends on sha1mh_pkg and sha1_message_hasher_macros.svh
`default_nettype none
`include "sha1_message_hasher_macros.svh"

module sha1mh_ctrl
    import sha1mh_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    has_byte,
    input  wire logic    last_byte,
    output logic         in_ready,
    input  wire status_t st,
    output cmd_t         cmd
);

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               first_reg, first_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            round_reg <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
            first_reg <= first_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        round_next = round_reg;
        first_next = first_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (has_byte && st.pos_last)
                    begin
                        state_next = ST_ROUND;
                        round_next = '0;
                        ret_next   = last_byte ? ST_PAD : ST_IDLE;
                        first_next = 1'b1;
                    end
                    else if (last_byte)
                    begin
                        state_next = ST_PAD;
                        first_next = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                first_next = 1'b0;
                if (st.pos_last)
                begin
                    state_next = ST_ROUND;
                    round_next = '0;
                    ret_next   = ST_PAD;
                end
                else if (st.pos_pre_len)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (st.pos_last)
                begin
                    state_next = ST_ROUND;
                    round_next = '0;
                    ret_next   = ST_DIGEST;
                end
            end
            ST_ROUND:
            begin
                round_next = round_reg + ROUND_W'(1);
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ret_reg;
            end
            ST_DIGEST:
            begin
                if (!st.out_hold)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.src         = SRC_MSG;
        cmd.round_idx   = round_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.push      = in_valid && has_byte;
                cmd.count_inc = in_valid && has_byte;
                cmd.load_work = in_valid && has_byte && st.pos_last;
            end
            ST_PAD:
            begin
                cmd.push      = 1'b1;
                cmd.src       = first_reg ? SRC_PAD : SRC_ZERO;
                cmd.load_work = st.pos_last;
            end
            ST_LEN:
            begin
                cmd.push      = 1'b1;
                cmd.src       = SRC_LEN;
                cmd.load_work = st.pos_last;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update_h = 1'b1;
            end
            ST_DIGEST:
            begin
                cmd.digest_load = !st.out_hold;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    `SHA1MH_ASSERT_NEXT(a_rounds_then_update,
        state_reg == ST_ROUND && round_reg == ROUND_LAST,
        state_reg == ST_UPDATE, "round 79 not followed by chain update")

    `SHA1MH_ASSERT_NEXT(a_full_block_starts_rounds,
        cmd.push && st.pos_last,
        state_reg == ST_ROUND && round_reg == '0, "full block did not start rounds")

    `SHA1MH_ASSERT_NOW(a_load_only_at_block_end,
        cmd.load_work, cmd.push && st.pos_last, "work load outside a block end")

endmodule

`default_nettype wire

[src/sha1mh_dp.sv]
// datapath of the sha1 message hasher: schedule window, chaining and work words,
// byte counters and digest output register; depends on sha1mh_pkg and the macros
`default_nettype none
`include "sha1_message_hasher_macros.svh"

module sha1mh_dp
    import sha1mh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] msg_byte,
    input  wire cmd_t       cmd,
    output status_t         st,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data
);

    logic [COUNT_W-1:0] count_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [31:0]        h_reg [0:4];
    logic [31:0]        win_reg [0:WIN_D-1];
    logic [23:0]        word_reg;
    logic [31:0]        a_reg, b_reg, c_reg, d_reg, e_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    logic [63:0] len_bits;
    logic [7:0]  byte_in;
    logic [31:0] expand;
    logic [31:0] w_cur;
    logic [31:0] t_next;

    assign len_bits = {count_reg, 3'b000};

    always_comb
    begin
        unique case (cmd.src)
            SRC_MSG:  byte_in = msg_byte;
            SRC_PAD:  byte_in = PAD_MARK;
            SRC_ZERO: byte_in = 8'h00;
            SRC_LEN:  byte_in = len_bits[{~pos_reg[2:0], 3'b000} +: 8];
            default:  byte_in = 8'h00;
        endcase
    end

    // window holds w[t-16..t-1]; first 16 rounds just rotate it
    assign expand = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_cur  = (cmd.round_idx < ROUND_W'(16)) ? win_reg[0] : {expand[30:0], expand[31]};
    assign t_next = {a_reg[26:0], a_reg[31:27]}
                  + sha1mh_round_f(cmd.round_idx, b_reg, c_reg, d_reg)
                  + e_reg + w_cur + sha1mh_round_k(cmd.round_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            if (cmd.push)
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (cmd.update_h)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            if (cmd.digest_load)
            begin
                count_reg <= '0;
                for (int i = 0; i < 5; i++)
                begin
                    h_reg[i] <= H_INIT[i];
                end
            end
            if (cmd.digest_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            word_reg <= {word_reg[15:0], byte_in};
            if (pos_reg[1:0] == 2'd3)
            begin
                for (int k = 0; k < WIN_D - 1; k++)
                begin
                    win_reg[k] <= win_reg[k+1];
                end
                win_reg[WIN_D-1] <= {word_reg, byte_in};
            end
        end
        if (cmd.round_en)
        begin
            for (int k = 0; k < WIN_D - 1; k++)
            begin
                win_reg[k] <= win_reg[k+1];
            end
            win_reg[WIN_D-1] <= w_cur;
            a_reg <= t_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.load_work)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        if (cmd.digest_load)
        begin
            out_reg.digest_word0 <= h_reg[0];
            out_reg.digest_word1 <= h_reg[1];
            out_reg.digest_word2 <= h_reg[2];
            out_reg.digest_word3 <= h_reg[3];
            out_reg.digest_word4 <= h_reg[4];
        end
    end

    assign st.pos_last    = (pos_reg == POS_BLOCK_END);
    assign st.pos_pre_len = (pos_reg == POS_BEFORE_LEN);
    assign st.out_hold    = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SHA1MH_ASSERT_NEXT(a_digest_sets_valid,
        cmd.digest_load, out_valid_reg, "digest load did not raise out_valid")

    `SHA1MH_ASSERT_NEXT(a_digest_clears_counts,
        cmd.digest_load, count_reg == '0 && pos_reg == '0,
        "counters not cleared after digest")

endmodule

`default_nettype wire

[src/sha1_message_hasher.sv]
// top level of the sha1 message hasher: sequencer plus datapath
// depends on sha1mh_pkg, sha1mh_ctrl and sha1mh_dp
//
//  channel | handshake            | beat
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | in_item_t: msg_byte, has_byte, last_byte
//  out     | out_valid / out_ready| out_item_t: digest_word0 .. digest_word4
//
// a byte that does not complete a 64-byte block is taken directly; one that does
// also runs the rounds on the single round unit and then the chain update
// message end: one pad or length byte per cycle up to block end, the rounds and
// chain update for each padded block, then the digest load
// reset loads the standard chaining words and clears the counts, no clearing pass
// one digest waits in the output register while the next message streams in;
// a further digest holds the sequencer until that register is taken
`default_nettype none

module sha1_message_hasher
    import sha1mh_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    cmd_t    cmd;
    status_t st;

    sha1mh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .has_byte  (in_data.has_byte),
        .last_byte (in_data.last_byte),
        .in_ready  (in_ready),
        .st        (st),
        .cmd       (cmd)
    );

    sha1mh_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_byte  (in_data.msg_byte),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
